@@ hdl/order1_adaptive_range_encoder_assert.svh @@
// Assertion macros for the order-1 range encoder.
`ifndef ORDER1_ADAPTIVE_RANGE_ENCODER_ASSERT_SVH
`define ORDER1_ADAPTIVE_RANGE_ENCODER_ASSERT_SVH

// Check a property every clock outside of reset.
`define O1RE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define O1RE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/o1re_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package o1re_pkg;
  localparam logic [0:0] CfgStep  = 1'b0;
  localparam logic [0:0] CfgLimit = 1'b1;
  localparam logic [7:0] StepReset   = 8'd4;
  localparam logic [15:0] LimitReset = 16'd16000;
  localparam logic [31:0] TopLimit = 32'h0100_0000;
  localparam logic [31:0] BotLimit = 32'h0001_0000;

  typedef enum logic [3:0] {
    StClear, StIdle, StFlush, StCum, StCumW, StDiv, StMul1, StMul2,
    StNorm, StAdapt, StResc, StRescW, StDone
  } state_e;
endpackage
`default_nettype wire

@@ hdl/order1_adaptive_range_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Order-1 adaptive carryless range encoder. Each encode transaction codes one byte
// with 256x256 adaptive 16-bit counts held in a single-port memory; a flush emits the
// four bytes of low, the last one tagged. After reset a clearing pass loads every
// count with one and every context total with 256 while in_ready_o stays low. An
// encode accepts the symbol, sums the counts below it (a memory read and an add per
// count), divides range by the total bit-serially, multiplies, emits its output
// bytes, does its bookkeeping and, when the context rescales, rewrites its 256
// counts. The memory port sets the pace; no new command or flush is taken until the
// current one is done.
module order1_adaptive_range_encoder
  import o1re_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  symbol_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);
  state_e state_q, state_d;
  logic [7:0]  step_q;
  logic [15:0] limit_q;
  logic [31:0] low_q, range_q;
  logic [7:0]  prev_q, sym_q;
  logic [15:0] tot_mem [256];
  logic [15:0] cnt_mem [65536];
  logic [15:0] rd_q;
  logic [15:0] tot_rd_q;
  logic [15:0] mem_addr;
  logic        mem_we;
  logic [15:0] mem_wd;
  logic [8:0]  idx_q;         // sweep index, bit 8 ends the sweep
  logic [16:0] clr_q;
  logic [31:0] cum_q, freq_q;
  logic [15:0] total_q;
  logic [31:0] quo_q, rem_q;
  logic [5:0]  div_q;
  logic [2:0]  nout_q;
  logic        ovalid_q, olast_q;
  logic [7:0]  obyte_q;
  logic [31:0] sum_q;
  logic [16:0] raised_tot;
  logic [16:0] raised_cnt;
  logic        resc;
  logic [31:0] hi, nr;
  logic        go1, go2;
  logic [32:0] rtrial;
  logic        emit_byte;

  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

  assign raised_tot = {1'b0, total_q} + {9'd0, step_q};
  assign raised_cnt = {1'b0, freq_q[15:0]} + {9'd0, step_q};
  assign resc       = (raised_tot > {1'b0, limit_q}) || raised_tot[16];
  assign hi         = low_q + range_q;
  assign go1        = ((low_q ^ hi) < TopLimit);
  assign go2        = range_q < BotLimit;
  assign nr         = go1 ? range_q : ((32'd0 - low_q) & (BotLimit - 32'd1));
  assign rtrial     = {rem_q, quo_q[31]} - {17'd0, total_q};

  // Load the output register when the slot is free and a byte is due.
  assign emit_byte  = (!ovalid_q || out_ready_i) && (nout_q != 3'd4) &&
                      ((state_q == StFlush) || (state_q == StNorm && (go1 || go2)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q[16]) state_d = StIdle;
      StIdle:  if (in_valid_i) state_d = cmd_i ? StFlush : StCum;
      StFlush: if (!ovalid_q || out_ready_i) begin
        if (nout_q == 3'd4) state_d = StIdle;
      end
      StCum:   state_d = StCumW;
      StCumW:  state_d = (idx_q[7:0] == sym_q) ? StDiv : StCum;
      StDiv:   if (div_q == 6'd32) state_d = StMul1;
      StMul1:  state_d = StMul2;
      StMul2:  state_d = StNorm;
      StNorm:  if (!ovalid_q || out_ready_i) begin
        if (nout_q == 3'd4 || !(go1 || go2)) state_d = StAdapt;
      end
      StAdapt: state_d = resc ? StResc : StDone;
      // Alternate a read state and a write state for each count.
      StResc:  state_d = idx_q[8] ? StDone : StRescW;
      StRescW: state_d = StResc;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_addr = {prev_q, idx_q[7:0]};
    mem_we = 1'b0;
    mem_wd = 16'd0;
    unique case (state_q)
      StClear: begin
        mem_addr = clr_q[15:0]; mem_we = !clr_q[16]; mem_wd = 16'd1;
      end
      StAdapt: begin
        mem_addr = {prev_q, sym_q}; mem_we = !resc; mem_wd = raised_cnt[15:0];
      end
      StRescW: begin
        mem_addr = {prev_q, idx_q[7:0]};
        mem_we = !idx_q[8];
        mem_wd = (((idx_q[7:0] == sym_q) ? raised_cnt[15:0] : rd_q) >> 1) | 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[mem_addr] <= mem_wd;
    rd_q <= cnt_mem[mem_addr];
  end

  // Context totals: loaded with 256 at the start of the clearing pass, while clr_q is below 256.
  always_ff @(posedge clk_i) begin
    if (state_q == StClear && clr_q[16:8] == 9'd0) begin
      tot_mem[clr_q[7:0]] <= 16'd256;
    end else if (state_q == StDone) begin
      tot_mem[prev_q] <= resc ? sum_q[15:0] : raised_tot[15:0];
    end
    tot_rd_q <= tot_mem[prev_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      step_q <= StepReset; limit_q <= LimitReset;
      low_q <= '0; range_q <= '1; prev_q <= '0;
      clr_q <= '0; ovalid_q <= 1'b0; olast_q <= 1'b0; nout_q <= '0;
      idx_q <= '0; div_q <= '0;
    end else begin
      state_q <= state_d;
      if (emit_byte) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        StClear: clr_q <= clr_q + 17'd1;
        StIdle: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == CfgStep) step_q <= cfg_data_i[7:0];
            else limit_q <= cfg_data_i;
          end
          if (in_valid_i) begin
            sym_q <= symbol_i;
            idx_q <= '0; cum_q <= '0; nout_q <= '0;
          end
        end
        StFlush: if (!ovalid_q || out_ready_i) begin
          if (nout_q != 3'd4) begin
            obyte_q <= low_q[31:24];
            olast_q <= (nout_q == 3'd3);
            low_q <= {low_q[23:0], 8'd0};
            nout_q <= nout_q + 3'd1;
          end
        end
        StCum: ;
        StCumW: begin
          if (idx_q[7:0] == sym_q) begin
            freq_q <= {16'd0, rd_q};
            total_q <= tot_rd_q;
            quo_q <= range_q; rem_q <= '0; div_q <= '0;
          end else begin
            cum_q <= cum_q + {16'd0, rd_q};
            idx_q <= idx_q + 9'd1;
          end
        end
        StDiv: if (div_q != 6'd32) begin
          // Restoring division, one quotient bit a cycle.
          if (!rtrial[32]) begin
            rem_q <= rtrial[31:0]; quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= {rem_q[30:0], quo_q[31]}; quo_q <= {quo_q[30:0], 1'b0};
          end
          div_q <= div_q + 6'd1;
        end
        StMul1: begin
          low_q <= low_q + cum_q * quo_q;
          range_q <= quo_q * freq_q;
        end
        StMul2: ;
        StNorm: if (!ovalid_q || out_ready_i) begin
          if (nout_q != 3'd4 && (go1 || go2)) begin
            obyte_q <= low_q[31:24];
            olast_q <= (nout_q == 3'd3) ||
                       !(((low_q << 8) ^ ((low_q << 8) + (nr << 8))) < TopLimit ||
                         (nr << 8) < BotLimit);
            low_q <= {low_q[23:0], 8'd0};
            range_q <= {nr[23:0], 8'd0};
            nout_q <= nout_q + 3'd1;
          end
        end
        StAdapt: begin idx_q <= '0; sum_q <= '0; end
        StResc: ;
        StRescW: if (!idx_q[8]) begin
          sum_q <= sum_q + {16'd0, mem_wd};
          idx_q <= idx_q + 9'd1;
        end
        StDone: prev_q <= sym_q;
        default: ;
      endcase
    end
  end

  `include "order1_adaptive_range_encoder_assert.svh"
  `O1RE_ASSERT(a_busy_not_ready, (state_q != StIdle) |-> !in_ready_o, "ready while busy")
  `O1RE_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> $stable(out_byte_o), "byte changed")
  `O1RE_ASSERT(a_flush_four, (state_q == StFlush && state_d == StIdle) |-> nout_q == 3'd4,
    "flush short")
  `O1RE_NEVER(a_nout_max, nout_q > 3'd4, "too many bytes")
endmodule
`default_nettype wire

@@ test/tb_order1_adaptive_range_encoder.sv @@
`timescale 1ns / 1ps
module tb_order1_adaptive_range_encoder;
  import o1re_pkg::*;

  // One compressed byte as the stream port should present it.
  typedef struct {
    logic [7:0] out_byte;
    logic       last;
  } coded_byte_t;

  // Scoreboard: mirrors the coder and its order-1 model, and checks the byte stream.
  class range_scoreboard;
    logic [31:0] low;
    logic [31:0] range;
    logic [7:0]  prev_sym;
    logic [15:0] counts [65536];
    logic [15:0] totals [256];
    logic [7:0]  step;
    logic [15:0] limit;
    coded_byte_t pending_q [$];
    int          mismatches;

    function new();
      low        = '0;
      range      = 32'hFFFF_FFFF;
      prev_sym   = '0;
      step       = StepReset;
      limit      = LimitReset;
      mismatches = 0;
      for (int i = 0; i < 65536; i++) counts[i] = 16'd1;
      for (int i = 0; i < 256; i++) totals[i] = 16'd256;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] data);
      if (idx == CfgStep) step = data[7:0];
      else limit = data;
    endfunction

    function void push_byte(logic [7:0] b, logic l);
      coded_byte_t e;
      e.out_byte = b;
      e.last     = l;
      pending_q.push_back(e);
    endfunction

    // Raise the coded symbol, or halve the whole context when its raised total passes the limit or 16 bits.
    function void update_model(logic [7:0] ctx, logic [7:0] sym);
      logic [15:0] base;
      logic [31:0] raised_total;
      logic [31:0] raised_count;
      logic [31:0] c;
      logic [31:0] sum;
      base         = {ctx, 8'h00};
      raised_total = 32'(totals[ctx]) + 32'(step);
      raised_count = 32'(counts[base | 16'(sym)]) + 32'(step);
      if (raised_total > 32'(limit) || raised_total > 32'hFFFF) begin
        sum = '0;
        for (int i = 0; i < 256; i++) begin
          c = (i == sym) ? raised_count : 32'(counts[base + 16'(i)]);
          c = (c >> 1) | 32'd1;
          counts[base + 16'(i)] = c[15:0];
          sum += c;
        end
        totals[ctx] = sum[15:0];
      end else begin
        counts[base | 16'(sym)] = raised_count[15:0];
        totals[ctx]             = raised_total[15:0];
      end
    endfunction

    // Predict the bytes caused by one accepted command.
    function void note_input(logic cmd, logic [7:0] sym);
      logic [15:0] base;
      logic [31:0] cum;
      logic [31:0] freq;
      logic [31:0] total;
      int          n;
      bit          go;
      if (cmd) begin
        for (int i = 0; i < 4; i++) begin
          push_byte(low[31:24], i == 3);
          low = low << 8;
        end
        return;
      end
      base  = {prev_sym, 8'h00};
      cum   = '0;
      freq  = 32'(counts[base | 16'(sym)]);
      total = 32'(totals[prev_sym]);
      for (int i = 0; i < sym; i++) cum += 32'(counts[base + 16'(i)]);
      if (total == 0) total = 1;
      range = range / total;
      low   = low + cum * range;
      range = range * freq;
      n = 0;
      while (n < 4) begin
        go = 0;
        if ((low ^ (low + range)) < TopLimit) begin
          go = 1;
        end else if (range < BotLimit) begin
          range = (32'd0 - low) & (BotLimit - 32'd1);
          go = 1;
        end
        if (!go) break;
        push_byte(low[31:24], 1'b0);
        n++;
        low   = low << 8;
        range = range << 8;
      end
      if (n > 0) pending_q[$].last = 1'b1;
      update_model(prev_sym, sym);
      prev_sym = sym;
    endfunction

    function void check_result(logic [7:0] b, logic l);
      coded_byte_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h last %0b", b, l);
        return;
      end
      e = pending_q.pop_front();
      if (b !== e.out_byte || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                   e.out_byte, e.last, b, l);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [7:0]  symbol_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_o;

  range_scoreboard sb;
  bit              no_idle;
  int              hold_req;

  order1_adaptive_range_encoder DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .symbol_i,
    .out_valid_o, .out_ready_i, .out_byte_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Check every byte the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_byte_o, last_o);
  end

  // Receiver: short stalls mostly, a few long ones, and one long hold-off on request.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        out_ready_i = 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!no_idle && $urandom_range(3) == 0)
          stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      end
    end
  end

  // Offer one command; hold it until the block takes the transaction.
  task automatic send_cmd(logic cmd, logic [7:0] sym);
    int gap;
    gap = no_idle ? 0 :
          (($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2));
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    symbol_i   = sym;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, sym);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Drain the stream and let a silent encode finish before touching registers.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random commands: repeat_pct percent on a two-symbol alphabet so contexts adapt and rescale.
  task automatic random_cmds(int n, int repeat_pct);
    logic [7:0] fav;
    logic [7:0] sym;
    int         r;
    fav = 8'($urandom_range(255));
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      sym = 8'($urandom_range(255));
      if (r < 6) send_cmd(1'b1, sym);
      else if (r < 6 + repeat_pct) send_cmd(1'b0, fav ^ 8'($urandom_range(1) << 7));
      else if (r < 94) send_cmd(1'b0, sym);
      else send_cmd(1'b0, ($urandom_range(1) != 0) ? 8'hFF : 8'h00);
    end
  endtask

  initial begin
    sb          = new();
    no_idle     = 1'b0;
    hold_req    = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgStep;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cmd_i       = 1'b0;
    symbol_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme symbols, flush from reset, encode after flush, back-to-back flushes.
    send_cmd(1'b1, 8'h00);
    send_cmd(1'b0, 8'h00);
    send_cmd(1'b0, 8'hFF);
    send_cmd(1'b0, 8'hFF);
    send_cmd(1'b0, 8'h00);
    send_cmd(1'b0, 8'hA5);
    send_cmd(1'b1, 8'hFF);
    send_cmd(1'b0, 8'h5A);
    send_cmd(1'b1, 8'h12);
    send_cmd(1'b1, 8'h34);
    for (int i = 0; i < 6; i++) send_cmd(1'b0, 8'h80);
    wait_idle();

    // Step of zero: counts freeze, coding must still run.
    write_reg(CfgStep, 16'h0000);
    write_reg(CfgLimit, 16'd300);
    for (int i = 0; i < 5; i++) send_cmd(1'b0, 8'h07);
    send_cmd(1'b1, 8'h00);
    wait_idle();

    // Largest step, smallest limit: a rescale on almost every symbol.
    write_reg(CfgStep, {8'($urandom_range(255)), 8'd255});
    write_reg(CfgLimit, 16'd256);
    random_cmds(20, 40);
    no_idle = 1'b1;
    random_cmds(10, 40);
    no_idle = 1'b0;
    wait_idle();

    // Smallest step, near-top limit; include a long receiver hold-off so input stalls.
    write_reg(CfgStep, {8'($urandom_range(255)), 8'd1});
    write_reg(CfgLimit, 16'd65000);
    hold_req = 4000;
    random_cmds(30, 30);
    wait_idle();

    // Top of the 16-bit total: one symbol repeated in its own context passes 65535.
    write_reg(CfgStep, 16'd255);
    write_reg(CfgLimit, 16'hFFFF);
    for (int i = 0; i < 260; i++) send_cmd(1'b0, 8'h3C);
    wait_idle();

    // A middle setting.
    write_reg(CfgStep, {8'($urandom_range(255)), 8'($urandom_range(2, 254))});
    write_reg(CfgLimit, 16'($urandom_range(400, 5000)));
    random_cmds(20, 50);
    send_cmd(1'b1, 8'h00);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
